// ----- src/dcpw_pkg.sv -----
// Shared types, constants and the field-to-speed function of the drive command parser.
package dcpw_pkg;

	localparam logic [7:0]  SEPARATOR     = 8'h3A;
	localparam logic [7:0]  CHAR_SPACE    = 8'h20;
	localparam logic [7:0]  CHAR_TAB      = 8'h09;
	localparam logic [7:0]  CHAR_CR       = 8'h0D;
	localparam logic [7:0]  CHAR_PLUS     = 8'h2B;
	localparam logic [7:0]  CHAR_MINUS    = 8'h2D;
	localparam logic [7:0]  CHAR_ZERO     = 8'h30;
	localparam logic [7:0]  CHAR_NINE     = 8'h39;
	localparam logic [13:0] ACC_MAX       = 14'd999;
	localparam logic [10:0] OFFSET_VALUE  = 11'd127;
	localparam logic [7:0]  SPEED_MAX     = 8'd255;
	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

	// configuration register indexes
	localparam logic CFG_TIMEOUT  = 1'b0;
	localparam logic CFG_OBSTACLE = 1'b1;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [9:0] left_acc;
		logic       left_neg;
		logic [9:0] right_acc;
		logic       right_neg;
	} fields_t;

	typedef struct packed {
		logic [7:0] speed;
		logic       rev;
	} side_t;

	// Field value (sign and magnitude) to speed and direction.
	function automatic side_t apply_field(input logic [9:0] acc, input logic neg);
		logic [10:0] acc_w;
		logic [10:0] mag;
		side_t       res;
		acc_w = {1'b0, acc};
		if (neg) begin
			mag = acc_w + OFFSET_VALUE;
		end else if (acc_w >= OFFSET_VALUE) begin
			mag = acc_w - OFFSET_VALUE;
		end else begin
			mag = OFFSET_VALUE - acc_w;
		end
		res.speed = (mag > 11'd127) ? SPEED_MAX : {mag[6:0], 1'b0};
		res.rev   = neg | (acc_w <= OFFSET_VALUE);
		return res;
	endfunction

endpackage

// ----- src/dcpw_ifs.sv -----
// Channel interfaces: command word in, drive status word out.
interface dcpw_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] command_byte;
	logic       end_of_command;
	logic       left_bumper;
	logic       right_bumper;

	modport source (output valid, operation, command_byte, end_of_command,
		left_bumper, right_bumper, input ready);
	modport sink (input valid, operation, command_byte, end_of_command,
		left_bumper, right_bumper, output ready);
endinterface

interface dcpw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_drive_speed;
	logic       left_reverse;
	logic [7:0] right_drive_speed;
	logic       right_reverse;
	logic       command_committed;

	modport source (output valid, left_drive_speed, left_reverse, right_drive_speed,
		right_reverse, command_committed, input ready);
	modport sink (input valid, left_drive_speed, left_reverse, right_drive_speed,
		right_reverse, command_committed, output ready);
endinterface

// ----- src/dcpw_parser.sv -----
// Byte-wise parser of the two colon-separated decimal fields.
module dcpw_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          cmd_byte,
	input  logic                commit,
	output dcpw_pkg::fields_t   fields
);

	logic              index_q;
	dcpw_pkg::phase_t  phase_q;
	logic              neg_q;
	dcpw_pkg::fields_t fields_q;

	logic              index_n;
	dcpw_pkg::phase_t  phase_n;
	logic              neg_n;
	dcpw_pkg::fields_t fields_n;
	logic              is_digit;
	logic              is_space;
	logic [9:0]        acc_cur;
	logic [13:0]       acc_sum;
	logic [9:0]        acc_new;
	logic              add;

	assign is_digit = (cmd_byte >= dcpw_pkg::CHAR_ZERO) && (cmd_byte <= dcpw_pkg::CHAR_NINE);
	assign is_space = (cmd_byte == dcpw_pkg::CHAR_SPACE) ||
		((cmd_byte >= dcpw_pkg::CHAR_TAB) && (cmd_byte <= dcpw_pkg::CHAR_CR));
	assign acc_cur  = index_q ? fields_q.right_acc : fields_q.left_acc;
	// acc*10 + digit, saturate at 999
	assign acc_sum  = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0} + {10'd0, cmd_byte[3:0]};
	assign acc_new  = (acc_sum > dcpw_pkg::ACC_MAX) ? dcpw_pkg::ACC_MAX[9:0] : acc_sum[9:0];

	always_comb begin
		index_n  = index_q;
		phase_n  = phase_q;
		neg_n    = neg_q;
		fields_n = fields_q;
		add      = 1'b0;
		if (cmd_byte == dcpw_pkg::SEPARATOR) begin
			if (!index_q) begin
				index_n = 1'b1;
				phase_n = dcpw_pkg::PH_SKIP;
				neg_n   = 1'b0;
			end else begin
				phase_n = dcpw_pkg::PH_DONE;
			end
		end else begin
			case (phase_q)
				dcpw_pkg::PH_SKIP: begin
					if (is_space) begin
						phase_n = dcpw_pkg::PH_SKIP;
					end else if ((cmd_byte == dcpw_pkg::CHAR_PLUS) ||
						(cmd_byte == dcpw_pkg::CHAR_MINUS)) begin
						neg_n   = (cmd_byte == dcpw_pkg::CHAR_MINUS);
						phase_n = dcpw_pkg::PH_SIGN;
					end else if (is_digit) begin
						add     = 1'b1;
						phase_n = dcpw_pkg::PH_DIGITS;
					end else begin
						phase_n = dcpw_pkg::PH_DONE;
					end
				end
				dcpw_pkg::PH_SIGN, dcpw_pkg::PH_DIGITS: begin
					if (is_digit) begin
						add     = 1'b1;
						phase_n = dcpw_pkg::PH_DIGITS;
					end else begin
						phase_n = dcpw_pkg::PH_DONE;
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
			if (index_q) begin
				fields_n.right_neg = neg_n;
				if (add) begin
					fields_n.right_acc = acc_new;
				end
			end else begin
				fields_n.left_neg = neg_n;
				if (add) begin
					fields_n.left_acc = acc_new;
				end
			end
		end
	end

	assign fields = fields_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q  <= 1'b0;
			phase_q  <= dcpw_pkg::PH_SKIP;
			neg_q    <= 1'b0;
			fields_q <= '0;
		end else if (step) begin
			if (commit) begin
				index_q  <= 1'b0;
				phase_q  <= dcpw_pkg::PH_SKIP;
				neg_q    <= 1'b0;
				fields_q <= '0;
			end else begin
				index_q  <= index_n;
				phase_q  <= phase_n;
				neg_q    <= neg_n;
				fields_q <= fields_n;
			end
		end
	end

endmodule

// ----- src/dcpw_drive.sv -----
// Speed and direction registers with idle watchdog and bumper stop.
module dcpw_drive (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  logic              tick,
	input  logic              bumper,
	input  dcpw_pkg::fields_t fields,
	input  logic [15:0]       timeout_ms,
	input  logic              obstacle_enable,
	output dcpw_pkg::side_t   left,
	output dcpw_pkg::side_t   right
);

	dcpw_pkg::side_t left_q;
	dcpw_pkg::side_t right_q;
	logic [15:0]     idle_q;

	dcpw_pkg::side_t left_cmd;
	dcpw_pkg::side_t right_cmd;
	logic [15:0]     idle_inc;
	logic            timed_out;
	logic            stop;

	assign left_cmd  = dcpw_pkg::apply_field(fields.left_acc, fields.left_neg);
	assign right_cmd = dcpw_pkg::apply_field(fields.right_acc, fields.right_neg);
	assign idle_inc  = (idle_q == dcpw_pkg::IDLE_MAX) ? idle_q : idle_q + 16'd1;
	assign timed_out = idle_inc > timeout_ms;
	assign stop      = obstacle_enable & bumper;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
			idle_q  <= '0;
		end else if (commit) begin
			left_q  <= left_cmd;
			right_q <= right_cmd;
			idle_q  <= '0;
		end else if (tick) begin
			idle_q <= idle_inc;
			// drop speed on timeout, or, with obstacle stop enabled, on a bumper hit for a forward side
			if (timed_out || (stop && !left_q.rev)) begin
				left_q.speed <= '0;
			end
			if (timed_out || (stop && !right_q.rev)) begin
				right_q.speed <= '0;
			end
		end
	end

	assign left  = left_q;
	assign right = right_q;

endmodule

// ----- src/drive_command_parser_watchdog_unit.sv -----
// Top level of the drive command parser with idle watchdog and bumper stop.
//
//   channel   dir  handshake      word
//   cmd_in    in   valid/ready    operation, command_byte, end_of_command, bumpers
//   drive_out out  valid/ready    speeds, directions, command_committed
//   cfg_*     in   cfg_wr_en      cfg_index, cfg_data (no read-back)
//
// One word per cycle while drive_out is not stalled; a word passes the input register,
// then the result register that also holds the drive state, before it shows on drive_out.
// arst_n clears parser, speeds, idle count, and loads the register defaults.
// A stalled drive_out holds its word; cmd_in still takes one more word into
// the input register and then holds ready low until drive_out moves.
module drive_command_parser_watchdog_unit (
	input  logic        clk,
	input  logic        arst_n,
	dcpw_in_if.sink     cmd_in,
	dcpw_out_if.source  drive_out,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	logic        operation_s1;
	logic [7:0]  byte_s1;
	logic        eoc_s1;
	logic        bumper_s1;
	logic        valid_s2;
	logic        committed_s2;
	logic [15:0] timeout_q;
	logic        obstacle_q;

	logic              advance;
	logic              byte_step;
	logic              commit;
	dcpw_pkg::fields_t fields;
	dcpw_pkg::side_t   left;
	dcpw_pkg::side_t   right;

	assign advance      = valid_s1 && (!valid_s2 || drive_out.ready);
	assign cmd_in.ready = !valid_s1 || advance;
	assign byte_step    = advance && !operation_s1;
	assign commit       = byte_step && eoc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= dcpw_pkg::TIMEOUT_RESET;
			obstacle_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dcpw_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_data;
				dcpw_pkg::CFG_OBSTACLE: obstacle_q <= cfg_data[0];
				default: timeout_q <= timeout_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_in.ready) begin
			valid_s1 <= cmd_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.ready && cmd_in.valid) begin
			operation_s1 <= cmd_in.operation;
			byte_s1      <= cmd_in.command_byte;
			eoc_s1       <= cmd_in.end_of_command;
			bumper_s1    <= cmd_in.left_bumper | cmd_in.right_bumper;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			committed_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2     <= 1'b1;
			committed_s2 <= commit;
		end else if (drive_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	dcpw_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (byte_step),
		.cmd_byte (byte_s1),
		.commit   (eoc_s1),
		.fields   (fields)
	);

	dcpw_drive u_drive (
		.clk             (clk),
		.arst_n          (arst_n),
		.commit          (commit),
		.tick            (advance && operation_s1),
		.bumper          (bumper_s1),
		.fields          (fields),
		.timeout_ms      (timeout_q),
		.obstacle_enable (obstacle_q),
		.left            (left),
		.right           (right)
	);

	// drive state only moves with advance, so it doubles as the held result word
	assign drive_out.valid             = valid_s2;
	assign drive_out.left_drive_speed  = left.speed;
	assign drive_out.left_reverse      = left.rev;
	assign drive_out.right_drive_speed = right.speed;
	assign drive_out.right_reverse     = right.rev;
	assign drive_out.command_committed = committed_s2;

endmodule
